// ===== sv/ab_slot_boot_selector_core_macros.svh =====
// Assertion macros used by the boot selector top level.
`ifndef AB_SLOT_BOOT_SELECTOR_CORE_MACROS_SVH
`define AB_SLOT_BOOT_SELECTOR_CORE_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define ABSBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a trigger in one cycle implies a consequence in the next.
`define ABSBS_ASSERT_NEXT(lbl, trig, cons, msg) \
	`ABSBS_ASSERT(lbl, (trig) |=> (cons), msg)

`endif

// ===== sv/absbs_pkg.sv =====
// Types, codes and helpers shared by the boot selector modules.
`default_nettype none
package absbs_pkg;

	// Slot state codes
	localparam logic [2:0] ST_EMPTY   = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_TESTING = 3'd2;
	localparam logic [2:0] ST_VALID   = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;

	// Commit register magic words
	localparam logic [31:0] MAGIC_COMMIT  = 32'h600D_C0DE;
	localparam logic [31:0] MAGIC_PENDING = 32'hBAAD_F00D;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SRAM_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRAM_HIGH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_A_BASE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_B_BASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 3'd5;

	// Configuration reset values
	localparam logic [31:0] RST_SRAM_LOW      = 32'h2000_0000;
	localparam logic [31:0] RST_SRAM_HIGH     = 32'h2001_0000;
	localparam logic [31:0] RST_SLOT_A_BASE   = 32'h0801_0000;
	localparam logic [31:0] RST_SLOT_B_BASE   = 32'h0804_0000;
	localparam logic [31:0] RST_SLOT_SIZE     = 32'h0002_0000;
	localparam logic [7:0]  RST_MAX_ATTEMPTS  = 8'd3;

	localparam logic [7:0] ATTEMPT_SAT = 8'hFF;

	typedef struct packed {
		logic        wdog_flag;
		logic [31:0] commit_word;
		logic        update_done;
		logic [31:0] update_size;
		logic [31:0] update_crc;
		logic [31:0] crc_a;
		logic [31:0] stack_a;
		logic [31:0] entry_a;
		logic [31:0] crc_b;
		logic [31:0] stack_b;
		logic [31:0] entry_b;
	} absbs_in_t;

	typedef struct packed {
		logic        outcome;
		logic        boot_slot;
		logic        arm_pending;
		logic [2:0]  state_a;
		logic [2:0]  state_b;
		logic [31:0] sequence_out;
	} absbs_out_t;

	// Persistent boot metadata for both slots
	typedef struct packed {
		logic [2:0]  st_a;
		logic [2:0]  st_b;
		logic [7:0]  att_a;
		logic [7:0]  att_b;
		logic [31:0] size_a;
		logic [31:0] size_b;
		logic [31:0] icrc_a;
		logic [31:0] icrc_b;
		logic        act;
		logic [31:0] seq;
	} absbs_state_t;

	localparam absbs_state_t STATE_RST = '{
		st_a: ST_VALID, st_b: ST_EMPTY, att_a: 8'd0, att_b: 8'd0,
		size_a: 32'd0, size_b: 32'd0, icrc_a: 32'd0, icrc_b: 32'd0,
		act: 1'b0, seq: 32'd0
	};

	// A slot in one of these states may still be booted
	function automatic logic st_bootable(input logic [2:0] st);
		return (st == ST_NEW) || (st == ST_TESTING) || (st == ST_VALID);
	endfunction

endpackage
`default_nettype wire

// ===== sv/absbs_apply_upd.sv =====
// Records a finished update in the inactive slot and makes it active.
`default_nettype none
module absbs_apply_upd (
	input  absbs_pkg::absbs_state_t cur,
	input  logic                    update_done,
	input  logic [31:0]             update_size,
	input  logic [31:0]             update_crc,
	output absbs_pkg::absbs_state_t nxt
);
	import absbs_pkg::*;

	always_comb begin
		nxt = cur;
		if (update_done) begin
			nxt.act = ~cur.act;
			nxt.seq = cur.seq + 32'd1;
			if (cur.act) begin
				nxt.st_a   = ST_NEW;
				nxt.att_a  = 8'd0;
				nxt.size_a = update_size;
				nxt.icrc_a = update_crc;
			end else begin
				nxt.st_b   = ST_NEW;
				nxt.att_b  = 8'd0;
				nxt.size_b = update_size;
				nxt.icrc_b = update_crc;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/absbs_slot_chk.sv =====
// Image checks of one slot: size, CRC, stack pointer range, entry vector.
`default_nettype none
module absbs_slot_chk (
	input  logic [31:0] image_size,
	input  logic [31:0] image_crc,
	input  logic [31:0] crc_calc,
	input  logic [31:0] stack_ptr,
	input  logic [31:0] entry_pc,
	input  logic [31:0] base,
	input  logic [31:0] capacity,
	input  logic [31:0] sram_low,
	input  logic [31:0] sram_high,
	output logic        ok
);
	logic [32:0] top;
	logic        size_ok, crc_ok, sp_ok, pc_ok;

	// Slot top is kept 33 bits wide so a slot reaching past 4 GiB does not wrap
	assign top     = {1'b0, base} + {1'b0, capacity};
	assign size_ok = (image_size != 32'd0) && (image_size <= capacity);
	assign crc_ok  = (crc_calc == image_crc);
	assign sp_ok   = (stack_ptr >= sram_low) && (stack_ptr <= sram_high);
	assign pc_ok   = entry_pc[0] && (entry_pc >= base) && ({1'b0, entry_pc} < top);
	assign ok      = size_ok && crc_ok && sp_ok && pc_ok;

endmodule
`default_nettype wire

// ===== sv/absbs_decide.sv =====
// Probation, trial counting, rollback and recovery decision for one boot.
`default_nettype none
module absbs_decide (
	input  absbs_pkg::absbs_state_t cur,
	input  logic                    wdog_flag,
	input  logic [31:0]             commit_word,
	input  logic                    chk_a,
	input  logic                    chk_b,
	input  logic [7:0]              max_attempts,
	output absbs_pkg::absbs_state_t nxt,
	output absbs_pkg::absbs_out_t   res
);
	import absbs_pkg::*;

	always_comb begin
		logic       act, oth, chk_act, chk_oth, outcome, pend;
		logic [2:0] st_act, st_oth;
		logic [7:0] att_act, att_oth;
		logic [1:0] seq_inc;

		act     = cur.act;
		oth     = ~cur.act;
		st_act  = act ? cur.st_b : cur.st_a;
		st_oth  = act ? cur.st_a : cur.st_b;
		att_act = act ? cur.att_b : cur.att_a;
		att_oth = act ? cur.att_a : cur.att_b;
		chk_act = act ? chk_b : chk_a;
		chk_oth = act ? chk_a : chk_b;
		outcome = 1'b1;
		pend    = 1'b0;
		seq_inc = 2'd0;

		// Resolve a trial boot left on probation
		if (st_act == ST_TESTING) begin
			if (commit_word == MAGIC_COMMIT) begin
				st_act  = ST_VALID;
				att_act = 8'd0;
			end else if (wdog_flag || (commit_word == MAGIC_PENDING)) begin
				st_act = ST_INVALID;
			end
		end

		if (st_bootable(st_act) && chk_act) begin
			if (st_act == ST_NEW) begin
				st_act  = ST_TESTING;
				att_act = 8'd1;
			end else if (st_act == ST_TESTING) begin
				if (att_act != ATTEMPT_SAT) att_act = att_act + 8'd1;
				if (att_act > max_attempts) st_act = ST_INVALID;
			end
			if (st_act != ST_INVALID) begin
				seq_inc = 2'd1;
				pend    = (st_act == ST_TESTING);
				outcome = 1'b0;
			end
		end else begin
			st_act = ST_INVALID;
		end

		// Roll back to the other slot
		if (outcome) begin
			seq_inc = 2'd1;
			if (st_bootable(st_oth) && chk_oth) begin
				act     = oth;
				att_oth = 8'd0;
				if (st_oth == ST_NEW) begin
					st_oth  = ST_TESTING;
					att_oth = 8'd1;
				end
				seq_inc = 2'd2;
				pend    = (st_oth == ST_TESTING);
				outcome = 1'b0;
			end
		end

		nxt     = cur;
		nxt.act = act;
		nxt.seq = cur.seq + {30'd0, seq_inc};
		if (cur.act) begin
			nxt.st_b  = st_act;
			nxt.att_b = att_act;
			nxt.st_a  = st_oth;
			nxt.att_a = att_oth;
		end else begin
			nxt.st_a  = st_act;
			nxt.att_a = att_act;
			nxt.st_b  = st_oth;
			nxt.att_b = att_oth;
		end

		res.outcome      = outcome;
		res.boot_slot    = act;
		res.arm_pending  = outcome ? 1'b0 : pend;
		res.state_a      = nxt.st_a;
		res.state_b      = nxt.st_b;
		res.sequence_out = nxt.seq;
	end

endmodule
`default_nettype wire

// ===== sv/ab_slot_boot_selector_core.sv =====
// Top level of the A/B slot boot selector with trial boots and rollback.
`default_nettype none
`include "ab_slot_boot_selector_core_macros.svh"
// Each input word describes one boot event: watchdog flag, commit register
// value, an optional finished update (size, CRC), and for both slots the
// computed CRC, initial stack pointer and reset vector. Each accepted word
// yields exactly one result word: recovery flag, slot to boot, whether the
// commit register is armed with the pending magic, both slot states and the
// metadata sequence number. Timing: a word is taken into the input register,
// the whole decision is made combinationally from there into the result
// register, and the result register loads once it is free or being drained;
// one word per cycle is sustained while out_ready stays high. That rate rests
// on the loop through the slot metadata registers: each boot reads what the
// previous one wrote. The input register holds a word while a finished
// result waits on out_ready.
// Configuration registers (cfg_idx): 0 sram_low, 1 sram_high, 2 slot_a_base,
// 3 slot_b_base, 4 slot capacity, 5 max_attempts (low 8 bits); other indexes
// are ignored. Write them only while the block is idle.
module ab_slot_boot_selector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [absbs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [31:0]                       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  absbs_pkg::absbs_in_t              in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output absbs_pkg::absbs_out_t             out_data
);
	import absbs_pkg::*;

	// Configuration registers
	logic [31:0] sram_low_q, sram_high_q, slot_a_base_q, slot_b_base_q, slot_cap_q;
	logic [7:0]  max_attempts_q;

	// Pipeline and metadata
	logic         valid_s1, valid_s2;
	absbs_in_t    in_s1;
	absbs_out_t   out_s2;
	absbs_state_t meta_q, meta_upd, meta_nxt;
	absbs_out_t   res;
	logic         chk_a, chk_b, advance;
	logic [2:0]   booted_st;
	logic         boot_st_ok;

	// Advance the input word when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sram_low_q      <= RST_SRAM_LOW;
			sram_high_q     <= RST_SRAM_HIGH;
			slot_a_base_q   <= RST_SLOT_A_BASE;
			slot_b_base_q   <= RST_SLOT_B_BASE;
			slot_cap_q      <= RST_SLOT_SIZE;
			max_attempts_q  <= RST_MAX_ATTEMPTS;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SRAM_LOW:      sram_low_q      <= cfg_wdata;
				CFG_SRAM_HIGH:     sram_high_q     <= cfg_wdata;
				CFG_SLOT_A_BASE:   slot_a_base_q   <= cfg_wdata;
				CFG_SLOT_B_BASE:   slot_b_base_q   <= cfg_wdata;
				CFG_SLOT_SIZE:     slot_cap_q      <= cfg_wdata;
				CFG_MAX_ATTEMPTS:  max_attempts_q  <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: load on acceptance, drop valid when the word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// Result register and slot metadata both advance with the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			meta_q   <= STATE_RST;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				meta_q   <= meta_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= res;
		end
	end

	// Update first: the checks below see the freshly recorded size and CRC
	absbs_apply_upd u_apply_upd (
		.cur         (meta_q),
		.update_done (in_s1.update_done),
		.update_size (in_s1.update_size),
		.update_crc  (in_s1.update_crc),
		.nxt         (meta_upd)
	);

	absbs_slot_chk u_chk_a (
		.image_size (meta_upd.size_a),
		.image_crc  (meta_upd.icrc_a),
		.crc_calc   (in_s1.crc_a),
		.stack_ptr  (in_s1.stack_a),
		.entry_pc   (in_s1.entry_a),
		.base       (slot_a_base_q),
		.capacity   (slot_cap_q),
		.sram_low   (sram_low_q),
		.sram_high  (sram_high_q),
		.ok         (chk_a)
	);

	absbs_slot_chk u_chk_b (
		.image_size (meta_upd.size_b),
		.image_crc  (meta_upd.icrc_b),
		.crc_calc   (in_s1.crc_b),
		.stack_ptr  (in_s1.stack_b),
		.entry_pc   (in_s1.entry_b),
		.base       (slot_b_base_q),
		.capacity   (slot_cap_q),
		.sram_low   (sram_low_q),
		.sram_high  (sram_high_q),
		.ok         (chk_b)
	);

	absbs_decide u_decide (
		.cur          (meta_upd),
		.wdog_flag    (in_s1.wdog_flag),
		.commit_word  (in_s1.commit_word),
		.chk_a        (chk_a),
		.chk_b        (chk_b),
		.max_attempts (max_attempts_q),
		.nxt          (meta_nxt),
		.res          (res)
	);

	// State of the slot named in the result word
	assign booted_st  = out_data.boot_slot ? out_data.state_b : out_data.state_a;
	assign boot_st_ok = (booted_st == ST_TESTING) || (booted_st == ST_VALID);

	// Recovery never arms the commit register
	`ABSBS_ASSERT(a_recovery_no_arm, (out_valid && out_data.outcome) |-> !out_data.arm_pending, "recovery armed")

	// A booted slot is on trial or known good
	`ABSBS_ASSERT(a_boot_state, (out_valid && !out_data.outcome) |-> boot_st_ok, "bad booted slot state")

	// Every boot moves the sequence number
	`ABSBS_ASSERT_NEXT(a_seq_moves, advance, meta_q.seq != $past(meta_q.seq), "sequence stuck")

endmodule
`default_nettype wire
